>>> rtl/ckvt_pkg.sv
// ----------------------------------------------------------------------------
// Compacting key/value table package
// Shared widths, operation and error codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ckvt_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int ACTION_W    = 3;
    localparam int OUT_VALUE_W = 32;
    localparam int COUNT_W     = 7;
    localparam int ERROR_W     = 2;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [ERROR_W-1:0]  error_t;

    localparam action_t ACT_GET   = 3'd0;
    localparam action_t ACT_WRITE = 3'd1;
    localparam action_t ACT_READ  = 3'd2;
    localparam action_t ACT_ERASE = 3'd3;
    localparam action_t ACT_CLEAR = 3'd4;

    localparam error_t ERR_OK     = 2'd0;
    localparam error_t ERR_ABSENT = 2'd1;
    localparam error_t ERR_EMPTY  = 2'd2;
    localparam error_t ERR_FULL   = 2'd3;

    typedef struct packed {
        logic load;
        logic scan_next;
        logic hit;
        logic update;
        logic shift_next;
        logic emit;
    } ckvt_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic match;
        logic idx_last;
        logic erase_hit;
    } ckvt_status_t;

endpackage

>>> rtl/ckvt_ctrl.sv
// ----------------------------------------------------------------------------
// Compacting key/value table controller
// Sequences the search, update, compaction and result hand-off of one item.
// ----------------------------------------------------------------------------
module ckvt_ctrl
    import ckvt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  ckvt_status_t status,
    output ckvt_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_emit;

    assign can_emit  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.need_scan ? S_SCAN : S_UPDATE;
                end
            end
            S_SCAN:
            begin
                if (status.match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_UPDATE;
                end
                else if (status.idx_last)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = (status.erase_hit && !status.idx_last) ? S_SHIFT : S_OUT;
            end
            S_SHIFT:
            begin
                cmd.shift_next = 1'b1;
                if (status.idx_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (can_emit)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/ckvt_datapath.sv
// ----------------------------------------------------------------------------
// Compacting key/value table datapath
// Holds the entry memories, the entry count, the request and the result
// registers, and performs the compare, insert, overwrite and compaction.
// ----------------------------------------------------------------------------
module ckvt_datapath
    import ckvt_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  action_t                action,
    input  logic [KEY_WIDTH-1:0]   key,
    input  logic [VALUE_WIDTH-1:0] new_value,
    input  ckvt_cmd_t              cmd,
    output ckvt_status_t           status,
    output logic [OUT_VALUE_W-1:0] value,
    output logic                   found,
    output logic [COUNT_W-1:0]     count,
    output error_t                 error
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [KEY_WIDTH-1:0]   key_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];

    logic [KEY_WIDTH-1:0]   rd_key_reg;
    logic [VALUE_WIDTH-1:0] rd_val_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [KEY_WIDTH-1:0]   wr_key;
    logic [VALUE_WIDTH-1:0] wr_val;

    logic [CNT_W-1:0]       count_reg,     count_next;
    logic [IDX_W-1:0]       scan_idx_reg,  scan_idx_next;
    action_t                act_reg,       act_next;
    logic [KEY_WIDTH-1:0]   key_reg,       key_next;
    logic [VALUE_WIDTH-1:0] nv_reg,        nv_next;
    logic                   found_reg,     found_next;
    logic [VALUE_WIDTH-1:0] hit_val_reg,   hit_val_next;
    logic [VALUE_WIDTH-1:0] res_value_reg, res_value_next;
    error_t                 res_error_reg, res_error_next;
    logic [OUT_VALUE_W-1:0] value_reg,     value_next;
    logic                   found_out_reg, found_out_next;
    logic [COUNT_W-1:0]     count_out_reg, count_out_next;
    error_t                 error_reg,     error_next;

    logic [CNT_W-1:0]       idx_plus_one;
    logic                   full;

    assign idx_plus_one = CNT_W'(scan_idx_reg) + CNT_W'(1);
    assign full         = (count_reg == CNT_W'(CAPACITY));

    assign status.need_scan = ((action == ACT_GET) || (action == ACT_WRITE) ||
                               (action == ACT_READ) || (action == ACT_ERASE)) &&
                              (count_reg != '0);
    assign status.match     = (rd_key_reg == key_reg);
    assign status.idx_last  = (idx_plus_one == count_reg);
    assign status.erase_hit = (act_reg == ACT_ERASE) && found_reg;

    assign value = value_reg;
    assign found = found_out_reg;
    assign count = count_out_reg;
    assign error = error_reg;

    always_comb
    begin
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        nv_next        = nv_reg;
        found_next     = found_reg;
        hit_val_next   = hit_val_reg;
        res_value_next = res_value_reg;
        res_error_next = res_error_reg;
        value_next     = value_reg;
        found_out_next = found_out_reg;
        count_out_next = count_out_reg;
        error_next     = error_reg;
        rd_addr        = scan_idx_reg;
        wr_en          = 1'b0;
        wr_addr        = scan_idx_reg;
        wr_key         = key_reg;
        wr_val         = nv_reg;

        if (cmd.load)
        begin
            act_next      = action;
            key_next      = key;
            nv_next       = new_value;
            found_next    = 1'b0;
            scan_idx_next = '0;
            rd_addr       = '0;
        end

        if (cmd.scan_next)
        begin
            scan_idx_next = scan_idx_reg + IDX_W'(1);
            rd_addr       = scan_idx_reg + IDX_W'(1);
        end

        if (cmd.hit)
        begin
            found_next   = 1'b1;
            hit_val_next = rd_val_reg;
        end

        if (cmd.update)
        begin
            res_value_next = '0;
            res_error_next = ERR_OK;
            case (act_reg) inside
                ACT_GET, ACT_WRITE:
                begin
                    if (found_reg)
                    begin
                        if (act_reg == ACT_WRITE)
                        begin
                            wr_en          = 1'b1;
                            res_value_next = nv_reg;
                        end
                        else
                        begin
                            res_value_next = hit_val_reg;
                        end
                    end
                    else if (full)
                    begin
                        res_error_next = ERR_FULL;
                    end
                    else
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = count_reg[IDX_W-1:0];
                        wr_val         = (act_reg == ACT_WRITE) ? nv_reg : '0;
                        res_value_next = wr_val;
                        count_next     = count_reg + CNT_W'(1);
                    end
                end
                ACT_READ:
                begin
                    if (found_reg)
                    begin
                        res_value_next = hit_val_reg;
                    end
                end
                ACT_ERASE:
                begin
                    if (found_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        rd_addr    = scan_idx_reg + IDX_W'(1);
                    end
                    else
                    begin
                        res_error_next = ERR_ABSENT;
                    end
                end
                ACT_CLEAR:
                begin
                    if (count_reg == '0)
                    begin
                        res_error_next = ERR_EMPTY;
                    end
                    else
                    begin
                        count_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.shift_next)
        begin
            wr_en         = 1'b1;
            wr_key        = rd_key_reg;
            wr_val        = rd_val_reg;
            scan_idx_next = scan_idx_reg + IDX_W'(1);
            rd_addr       = scan_idx_reg + IDX_W'(2);
        end

        if (cmd.emit)
        begin
            value_next     = OUT_VALUE_W'(res_value_reg);
            found_out_next = found_reg;
            count_out_next = COUNT_W'(count_reg);
            error_next     = res_error_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg  <= scan_idx_next;
        act_reg       <= act_next;
        key_reg       <= key_next;
        nv_reg        <= nv_next;
        found_reg     <= found_next;
        hit_val_reg   <= hit_val_next;
        res_value_reg <= res_value_next;
        res_error_reg <= res_error_next;
        value_reg     <= value_next;
        found_out_reg <= found_out_next;
        count_out_reg <= count_out_next;
        error_reg     <= error_next;
    end

endmodule

>>> rtl/compacting_key_value_table.sv
// ----------------------------------------------------------------------------
// Compacting key/value table
// Insertion-ordered key/value table with linear search and compaction on erase.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (action, key, new_value) and are taken
// when in_valid is high and in_stall is low. Each request gives exactly one
// result on the output channel (value, found, count, error), taken when
// out_valid is high and out_stall is low.
// The block works on one item at a time. The search reads one entry per cycle
// from the entry memory, and an erase moves one later entry down per cycle.
// The search stops at the first entry whose key matches, and a miss reads
// all count entries; clear, undefined actions and an empty table skip the
// search. An erase at position p moves every entry after p down by one.
// A new item is accepted as soon as the previous result sits in the output
// register, even while the receiver stalls; it then waits at its end until
// that result has been taken. A stalled result holds its value.
// Reset empties the table; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
module compacting_key_value_table
    import ckvt_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  action_t                action,
    input  logic [KEY_WIDTH-1:0]   key,
    input  logic [VALUE_WIDTH-1:0] new_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [OUT_VALUE_W-1:0] value,
    output logic                   found,
    output logic [COUNT_W-1:0]     count,
    output error_t                 error
);

    ckvt_cmd_t    cmd;
    ckvt_status_t status;

    ckvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ckvt_datapath #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .action    (action),
        .key       (key),
        .new_value (new_value),
        .cmd       (cmd),
        .status    (status),
        .value     (value),
        .found     (found),
        .count     (count),
        .error     (error)
    );

endmodule

>>> rtl/ckvt_checker.sv
// ----------------------------------------------------------------------------
// Compacting key/value table checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ckvt_checker
    import ckvt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [OUT_VALUE_W-1:0] value,
    input logic                   found,
    input logic [COUNT_W-1:0]     count,
    input error_t                 error
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(found) &&
                                   $stable(count) && $stable(error))
        else $error("A stalled result changed or was dropped.");

    a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error == ERR_FULL || error == ERR_ABSENT) |-> !found && (value == '0))
        else $error("A refused or missing key reported a value or a hit.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error == ERR_FULL) |-> (count == COUNT_W'(CAPACITY)))
        else $error("A full-table error was reported below capacity.");

    a_empty_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error == ERR_EMPTY) |-> (count == '0) && !found && (value == '0))
        else $error("An empty-table error was reported with entries present.");

endmodule

bind compacting_key_value_table ckvt_checker #(.CAPACITY(CAPACITY)) u_ckvt_checker (.*);

>>> tb/compacting_key_value_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compacting key/value table testbench
// Sends table requests through a queue-fed driver. Each accepted item runs
// through a local copy of the table to predict its result. A monitor compares
// every result with the oldest prediction. The run covers directed corner
// cases, fills of the whole table and random traffic under several idling
// patterns. One phase holds the receiver off long enough to stall the input.
// ----------------------------------------------------------------------------
module compacting_key_value_table_tb;
    import ckvt_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int KW           = KEY_WIDTH_DEF;
    localparam int VW           = VALUE_WIDTH_DEF;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 600;
    localparam int SETTLE_CYCLES = 2 * CAP + 16;
    localparam int PRINT_LIMIT  = 50;

    localparam action_t ACT_UNDEF_LO = ACT_CLEAR + 3'd1;
    localparam action_t ACT_UNDEF_HI = {ACTION_W{1'b1}};

    typedef struct packed {
        action_t         action;
        logic [KW-1:0]   key;
        logic [VW-1:0]   new_value;
    } table_req_t;

    typedef struct packed {
        logic [OUT_VALUE_W-1:0] value;
        logic                   found;
        logic [COUNT_W-1:0]     count;
        error_t                 error;
    } table_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    action_t                action = ACT_GET;
    logic [KW-1:0]          key = '0;
    logic [VW-1:0]          new_value = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [OUT_VALUE_W-1:0] value;
    logic                   found;
    logic [COUNT_W-1:0]     count;
    error_t                 error;

    table_req_t    pending_requests[$];
    table_result_t expected_results[$];
    table_req_t    next_request;
    table_result_t oldest_result;

    logic [KW-1:0] shadow_keys[CAP];
    logic [VW-1:0] shadow_values[CAP];
    int            shadow_count = 0;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    logic hold_arm = 1'b0;
    int hold_left = 0;
    int mismatch_count = 0;
    int results_taken = 0;
    int cycle_count = 0;

    compacting_key_value_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .key       (key),
        .new_value (new_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .found     (found),
        .count     (count),
        .error     (error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic table_result_t predict_table_op(action_t act, logic [KW-1:0] k,
                                                       logic [VW-1:0] nv);
        table_result_t r;
        int            idx;
        int            j;
        r = '0;
        idx = -1;
        if (act <= ACT_ERASE)
        begin
            for (j = 0; j < shadow_count; j++)
            begin
                if (idx < 0 && shadow_keys[j] == k)
                begin
                    idx = j;
                end
            end
            r.found = (idx >= 0);
        end
        case (act)
            ACT_GET, ACT_WRITE:
            begin
                if (idx < 0)
                begin
                    if (shadow_count >= CAP)
                    begin
                        r.error = ERR_FULL;
                    end
                    else
                    begin
                        idx = shadow_count;
                        shadow_keys[idx] = k;
                        shadow_values[idx] = '0;
                        shadow_count++;
                    end
                end
                if (r.error != ERR_FULL)
                begin
                    if (act == ACT_WRITE)
                    begin
                        shadow_values[idx] = nv;
                    end
                    r.value = shadow_values[idx];
                end
            end
            ACT_READ:
            begin
                if (idx >= 0)
                begin
                    r.value = shadow_values[idx];
                end
            end
            ACT_ERASE:
            begin
                if (idx < 0)
                begin
                    r.error = ERR_ABSENT;
                end
                else
                begin
                    for (j = idx; j + 1 < shadow_count; j++)
                    begin
                        shadow_keys[j] = shadow_keys[j + 1];
                        shadow_values[j] = shadow_values[j + 1];
                    end
                    shadow_count--;
                end
            end
            ACT_CLEAR:
            begin
                if (shadow_count == 0)
                begin
                    r.error = ERR_EMPTY;
                end
                else
                begin
                    shadow_count = 0;
                end
            end
            default:
            begin
            end
        endcase
        r.count = shadow_count[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("[%0t] mismatch on result %0d: %s", $realtime, results_taken, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= ACT_GET;
            key <= '0;
            new_value <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(predict_table_op(action, key, new_value));
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    next_request = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    action <= next_request.action;
                    key <= next_request.key;
                    new_value <= next_request.new_value;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result arrived with no request outstanding");
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (value !== oldest_result.value)
                    begin
                        report_mismatch($sformatf("value %h, expected %h",
                                                  value, oldest_result.value));
                    end
                    if (found !== oldest_result.found)
                    begin
                        report_mismatch($sformatf("found %b, expected %b",
                                                  found, oldest_result.found));
                    end
                    if (count !== oldest_result.count)
                    begin
                        report_mismatch($sformatf("count %0d, expected %0d",
                                                  count, oldest_result.count));
                    end
                    if (error !== oldest_result.error)
                    begin
                        report_mismatch($sformatf("error %0d, expected %0d",
                                                  error, oldest_result.error));
                    end
                end
                results_taken++;
            end
            out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_arm)
        begin
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_request(action_t act, logic [KW-1:0] k, logic [VW-1:0] nv);
        table_req_t req;
        req.action = act;
        req.key = k;
        req.new_value = nv;
        pending_requests.push_back(req);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(negedge clk);
        sender_idle_pct = send_pct;
        receiver_stall_pct = recv_pct;
    endtask

    task automatic wait_requests_taken();
        while (pending_requests.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic queue_random_ops(int n);
        logic [KW-1:0] pool[16];
        int            i;
        int            pick;
        action_t       act;
        for (i = 0; i < 16; i++)
        begin
            pool[i] = $urandom;
        end
        pool[0] = '0;
        pool[1] = '1;
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 28)
                act = ACT_GET;
            else if (pick < 55)
                act = ACT_WRITE;
            else if (pick < 70)
                act = ACT_READ;
            else if (pick < 90)
                act = ACT_ERASE;
            else if (pick < 93)
                act = ACT_CLEAR;
            else if (pick < 96)
                act = action_t'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
            else
                act = action_t'($urandom_range(0, ACT_UNDEF_HI));
            if (pick >= 96)
                push_request(act, $urandom, $urandom);
            else
                push_request(act, pool[$urandom_range(0, 15)], $urandom);
        end
    endtask

    task automatic queue_fill_sequence();
        logic [KW-1:0] base;
        int            i;
        int            pick;
        base = $urandom;
        for (i = 0; i < CAP + 3; i++)
        begin
            push_request((i % 2 == 0) ? ACT_WRITE : ACT_GET, base + i, $urandom);
        end
        push_request(ACT_ERASE, base, '0);
        push_request(ACT_ERASE, base + CAP - 1, '0);
        push_request(ACT_ERASE, base + CAP / 2, '0);
        push_request(ACT_READ, base + 1, '0);
        push_request(ACT_WRITE, base + CAP + 10, $urandom);
        for (i = 0; i < 24; i++)
        begin
            pick = $urandom_range(0, 3);
            push_request((pick == 0) ? ACT_READ : (pick == 1) ? ACT_ERASE :
                         (pick == 2) ? ACT_WRITE : ACT_GET,
                         base + $urandom_range(0, CAP + 12), $urandom);
        end
        push_request(ACT_CLEAR, '0, '0);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_idling(0, 0);
        push_request(ACT_READ, '0, '0);
        push_request(ACT_ERASE, 32'h0000_0005, '0);
        push_request(ACT_CLEAR, '0, '1);
        push_request(ACT_GET, '0, '1);
        push_request(ACT_WRITE, '1, '1);
        push_request(ACT_WRITE, '0, 32'hA5A5_A5A5);
        push_request(ACT_GET, '1, '0);
        push_request(ACT_READ, '0, '1);
        push_request(ACT_READ, 32'h1234_5678, '0);
        push_request(ACT_WRITE, 32'h8000_0000, '0);
        push_request(ACT_ERASE, '0, '0);
        push_request(ACT_READ, '1, '0);
        push_request(ACT_UNDEF_LO, '1, '1);
        push_request(ACT_UNDEF_LO + 3'd1, 32'h8000_0000, '0);
        push_request(ACT_UNDEF_HI, $urandom, $urandom);
        push_request(ACT_ERASE, '1, '0);
        push_request(ACT_ERASE, '0, '0);
        push_request(ACT_GET, 32'h8000_0000, '1);
        push_request(ACT_CLEAR, '0, '0);
        push_request(ACT_GET, 32'h0000_0001, '0);
        push_request(ACT_ERASE, 32'h0000_0001, '0);
        queue_fill_sequence();
        queue_random_ops(200);
        wait_requests_taken();

        set_idling(79, 0);
        queue_random_ops(220);
        wait_requests_taken();

        set_idling(0, 79);
        queue_fill_sequence();
        queue_random_ops(160);
        wait_requests_taken();

        set_idling(6, 6);
        queue_random_ops(250);
        wait_requests_taken();

        set_idling(0, 0);
        hold_arm = 1'b1;
        @(negedge clk);
        hold_arm = 1'b0;
        queue_random_ops(150);
        wait_requests_taken();

        set_idling(0, 0);
        queue_random_ops(100);

        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
